>>> hdl/cpu_opcode_decoder_assert.svh
// Assertion macros for the opcode decoder. Clock clk_i, reset rst_ni (active low).
`ifndef CPU_OPCODE_DECODER_ASSERT_SVH
`define CPU_OPCODE_DECODER_ASSERT_SVH

// Same-cycle implication.
`define COD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define COD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/cod_pkg.sv
`timescale 1ns / 1ps

package cod_pkg;

  typedef enum logic [5:0] {
    K_NONE, K_LD, K_INC, K_DEC, K_ADD, K_ADC, K_SUB, K_SBC, K_AND, K_XOR,
    K_OR, K_CP, K_PUSH, K_POP, K_RST, K_HALT, K_NOP, K_RLCA, K_RRCA,
    K_RLA, K_RRA, K_STOP, K_DAA, K_CPL, K_SCF, K_CCF, K_JR, K_JP, K_CALL,
    K_RET, K_RETI, K_DI, K_EI, K_RLC, K_RRC, K_RL, K_RR, K_SLA, K_SRA,
    K_SWAP, K_SRL, K_BIT, K_RES, K_SET
  } kind_e;

  typedef enum logic [2:0] {
    S_NONE, S_REG, S_PAIR, S_IND, S_IMM8, S_IMM16, S_SIMM8
  } opnd_e;

  typedef enum logic [3:0] {
    R_NONE, R_A, R_B, R_C, R_D, R_E, R_H, R_L, R_AF, R_BC, R_DE, R_HL, R_SP
  } reg_e;

  typedef enum logic [2:0] {
    L_NONE, L_TYP, L_INC, L_DEC, L_SP, L_IO, L_OFS
  } ldsub_e;

  typedef enum logic [2:0] {
    C_ALWAYS, C_NZ, C_Z, C_NC, C_C
  } cond_e;

  // Decoded instruction, one result word.
  typedef struct packed {
    logic       illegal;
    kind_e      kind;
    ldsub_e     sub;
    opnd_e      src_kind;
    reg_e       src_reg;
    opnd_e      dst_kind;
    reg_e       dst_reg;
    cond_e      cond;
    logic [2:0] bit_idx;
    logic [5:0] vec;
  } dec_t;

  localparam int unsigned OutDataW = 40;
  localparam int unsigned DecW     = $bits(dec_t);

  localparam dec_t DecZero = '{
    illegal: 1'b0, kind: K_NONE, sub: L_NONE, src_kind: S_NONE, src_reg: R_NONE,
    dst_kind: S_NONE, dst_reg: R_NONE, cond: C_ALWAYS, bit_idx: 3'd0, vec: 6'd0
  };

  function automatic reg_e r8_reg(input logic [2:0] idx);
    reg_e r;
    case (idx)
      3'd0:    r = R_B;
      3'd1:    r = R_C;
      3'd2:    r = R_D;
      3'd3:    r = R_E;
      3'd4:    r = R_H;
      3'd5:    r = R_L;
      3'd6:    r = R_HL;
      default: r = R_A;
    endcase
    return r;
  endfunction

  // Index 6 is (HL).
  function automatic opnd_e r8_kind(input logic [2:0] idx);
    return (idx == 3'd6) ? S_IND : S_REG;
  endfunction

  function automatic reg_e r16sp_reg(input logic [1:0] p);
    reg_e r;
    case (p)
      2'd0:    r = R_BC;
      2'd1:    r = R_DE;
      2'd2:    r = R_HL;
      default: r = R_SP;
    endcase
    return r;
  endfunction

  function automatic reg_e r16af_reg(input logic [1:0] p);
    reg_e r;
    case (p)
      2'd0:    r = R_BC;
      2'd1:    r = R_DE;
      2'd2:    r = R_HL;
      default: r = R_AF;
    endcase
    return r;
  endfunction

  function automatic kind_e alu_kind(input logic [2:0] y);
    kind_e k;
    case (y)
      3'd0:    k = K_ADD;
      3'd1:    k = K_ADC;
      3'd2:    k = K_SUB;
      3'd3:    k = K_SBC;
      3'd4:    k = K_AND;
      3'd5:    k = K_XOR;
      3'd6:    k = K_OR;
      default: k = K_CP;
    endcase
    return k;
  endfunction

  function automatic kind_e rot_kind(input logic [2:0] y);
    kind_e k;
    case (y)
      3'd0:    k = K_RLC;
      3'd1:    k = K_RRC;
      3'd2:    k = K_RL;
      3'd3:    k = K_RR;
      3'd4:    k = K_SLA;
      3'd5:    k = K_SRA;
      3'd6:    k = K_SWAP;
      default: k = K_SRL;
    endcase
    return k;
  endfunction

  // Condition from the low two bits of y: NZ, Z, NC, C.
  function automatic cond_e cond_of(input logic [1:0] y_lo);
    return cond_e'({1'b0, y_lo} + 3'd1);
  endfunction

endpackage

>>> hdl/cod_decode.sv
`timescale 1ns / 1ps

module cod_decode (
  input  logic           prefixed_i,
  input  logic [7:0]     opcode_i,
  output cod_pkg::dec_t  dec_o
);

  logic [1:0] x;
  logic [2:0] y;
  logic [2:0] z;
  logic [1:0] p;
  logic       q;

  assign x = opcode_i[7:6];
  assign y = opcode_i[5:3];
  assign z = opcode_i[2:0];
  assign p = opcode_i[5:4];
  assign q = opcode_i[3];

  always_comb begin
    cod_pkg::dec_t d;
    logic          bad;
    d   = cod_pkg::DecZero;
    bad = 1'b0;
    if (prefixed_i) begin
      if (x == 2'd0) begin
        d.kind = cod_pkg::rot_kind(y);
      end else begin
        d.kind    = (x == 2'd1) ? cod_pkg::K_BIT :
                    (x == 2'd2) ? cod_pkg::K_RES : cod_pkg::K_SET;
        d.bit_idx = y;
      end
      d.src_kind = cod_pkg::r8_kind(z);
      d.src_reg  = cod_pkg::r8_reg(z);
    end else begin
      case (x)
        2'd1: begin
          if (y == 3'd6 && z == 3'd6) begin
            d.kind = cod_pkg::K_HALT;
          end else begin
            d.kind     = cod_pkg::K_LD;
            d.sub      = cod_pkg::L_TYP;
            d.dst_kind = cod_pkg::r8_kind(y);
            d.dst_reg  = cod_pkg::r8_reg(y);
            d.src_kind = cod_pkg::r8_kind(z);
            d.src_reg  = cod_pkg::r8_reg(z);
          end
        end
        2'd2: begin
          d.kind     = cod_pkg::alu_kind(y);
          d.dst_kind = cod_pkg::S_REG;
          d.dst_reg  = cod_pkg::R_A;
          d.src_kind = cod_pkg::r8_kind(z);
          d.src_reg  = cod_pkg::r8_reg(z);
        end
        2'd0: begin
          case (z)
            3'd0: begin
              case (y)
                3'd0: d.kind = cod_pkg::K_NOP;
                3'd1: begin
                  // LD (a16),SP
                  d.kind     = cod_pkg::K_LD;
                  d.sub      = cod_pkg::L_SP;
                  d.src_kind = cod_pkg::S_PAIR;
                  d.src_reg  = cod_pkg::R_SP;
                  d.dst_kind = cod_pkg::S_IMM16;
                end
                3'd2: d.kind = cod_pkg::K_STOP;
                3'd3: begin
                  d.kind     = cod_pkg::K_JR;
                  d.src_kind = cod_pkg::S_SIMM8;
                end
                default: begin
                  d.kind     = cod_pkg::K_JR;
                  d.src_kind = cod_pkg::S_SIMM8;
                  d.cond     = cod_pkg::cond_of(y[1:0]);
                end
              endcase
            end
            3'd1: begin
              if (q) begin
                d.kind     = cod_pkg::K_ADD;
                d.src_kind = cod_pkg::S_PAIR;
                d.src_reg  = cod_pkg::r16sp_reg(p);
                d.dst_kind = cod_pkg::S_PAIR;
                d.dst_reg  = cod_pkg::R_HL;
              end else begin
                d.kind     = cod_pkg::K_LD;
                d.sub      = cod_pkg::L_TYP;
                d.src_kind = cod_pkg::S_IMM16;
                d.dst_kind = cod_pkg::S_PAIR;
                d.dst_reg  = cod_pkg::r16sp_reg(p);
              end
            end
            3'd2: begin
              // (BC), (DE), (HL+), (HL-) against A
              cod_pkg::reg_e   pr;
              cod_pkg::ldsub_e ps;
              pr = (p == 2'd0) ? cod_pkg::R_BC :
                   (p == 2'd1) ? cod_pkg::R_DE : cod_pkg::R_HL;
              ps = (p == 2'd2) ? cod_pkg::L_INC :
                   (p == 2'd3) ? cod_pkg::L_DEC : cod_pkg::L_TYP;
              d.kind = cod_pkg::K_LD;
              d.sub  = ps;
              if (q) begin
                d.src_kind = cod_pkg::S_IND;
                d.src_reg  = pr;
                d.dst_kind = cod_pkg::S_REG;
                d.dst_reg  = cod_pkg::R_A;
              end else begin
                d.src_kind = cod_pkg::S_REG;
                d.src_reg  = cod_pkg::R_A;
                d.dst_kind = cod_pkg::S_IND;
                d.dst_reg  = pr;
              end
            end
            3'd3: begin
              d.kind     = q ? cod_pkg::K_DEC : cod_pkg::K_INC;
              d.src_kind = cod_pkg::S_PAIR;
              d.dst_kind = cod_pkg::S_PAIR;
              d.src_reg  = cod_pkg::r16sp_reg(p);
              d.dst_reg  = cod_pkg::r16sp_reg(p);
            end
            3'd4, 3'd5: begin
              d.kind     = (z == 3'd4) ? cod_pkg::K_INC : cod_pkg::K_DEC;
              d.src_kind = cod_pkg::r8_kind(y);
              d.src_reg  = cod_pkg::r8_reg(y);
              d.dst_kind = cod_pkg::r8_kind(y);
              d.dst_reg  = cod_pkg::r8_reg(y);
            end
            3'd6: begin
              d.kind     = cod_pkg::K_LD;
              d.sub      = cod_pkg::L_TYP;
              d.src_kind = cod_pkg::S_IMM8;
              d.dst_kind = cod_pkg::r8_kind(y);
              d.dst_reg  = cod_pkg::r8_reg(y);
            end
            default: begin
              case (y)
                3'd0:    d.kind = cod_pkg::K_RLCA;
                3'd1:    d.kind = cod_pkg::K_RRCA;
                3'd2:    d.kind = cod_pkg::K_RLA;
                3'd3:    d.kind = cod_pkg::K_RRA;
                3'd4:    d.kind = cod_pkg::K_DAA;
                3'd5:    d.kind = cod_pkg::K_CPL;
                3'd6:    d.kind = cod_pkg::K_SCF;
                default: d.kind = cod_pkg::K_CCF;
              endcase
            end
          endcase
        end
        default: begin
          // x == 3
          case (z)
            3'd0: begin
              case (y)
                3'd4: begin
                  d.kind     = cod_pkg::K_LD;
                  d.sub      = cod_pkg::L_IO;
                  d.src_kind = cod_pkg::S_REG;
                  d.src_reg  = cod_pkg::R_A;
                  d.dst_kind = cod_pkg::S_IMM8;
                end
                3'd5: begin
                  d.kind     = cod_pkg::K_ADD;
                  d.src_kind = cod_pkg::S_SIMM8;
                  d.dst_kind = cod_pkg::S_PAIR;
                  d.dst_reg  = cod_pkg::R_SP;
                end
                3'd6: begin
                  d.kind     = cod_pkg::K_LD;
                  d.sub      = cod_pkg::L_IO;
                  d.src_kind = cod_pkg::S_IMM8;
                  d.dst_kind = cod_pkg::S_REG;
                  d.dst_reg  = cod_pkg::R_A;
                end
                3'd7: begin
                  d.kind     = cod_pkg::K_LD;
                  d.sub      = cod_pkg::L_OFS;
                  d.src_kind = cod_pkg::S_SIMM8;
                  d.dst_kind = cod_pkg::S_PAIR;
                  d.dst_reg  = cod_pkg::R_HL;
                end
                default: begin
                  d.kind = cod_pkg::K_RET;
                  d.cond = cod_pkg::cond_of(y[1:0]);
                end
              endcase
            end
            3'd1: begin
              if (!q) begin
                d.kind     = cod_pkg::K_POP;
                d.dst_kind = cod_pkg::S_PAIR;
                d.dst_reg  = cod_pkg::r16af_reg(p);
              end else begin
                case (p)
                  2'd0: d.kind = cod_pkg::K_RET;
                  2'd1: d.kind = cod_pkg::K_RETI;
                  2'd2: begin
                    d.kind     = cod_pkg::K_JP;
                    d.src_kind = cod_pkg::S_PAIR;
                    d.src_reg  = cod_pkg::R_HL;
                  end
                  default: begin
                    d.kind     = cod_pkg::K_LD;
                    d.sub      = cod_pkg::L_TYP;
                    d.src_kind = cod_pkg::S_PAIR;
                    d.src_reg  = cod_pkg::R_HL;
                    d.dst_kind = cod_pkg::S_PAIR;
                    d.dst_reg  = cod_pkg::R_SP;
                  end
                endcase
              end
            end
            3'd2: begin
              case (y)
                3'd4: begin
                  d.kind     = cod_pkg::K_LD;
                  d.sub      = cod_pkg::L_IO;
                  d.src_kind = cod_pkg::S_REG;
                  d.src_reg  = cod_pkg::R_A;
                  d.dst_kind = cod_pkg::S_IND;
                  d.dst_reg  = cod_pkg::R_C;
                end
                3'd5: begin
                  d.kind     = cod_pkg::K_LD;
                  d.sub      = cod_pkg::L_TYP;
                  d.src_kind = cod_pkg::S_REG;
                  d.src_reg  = cod_pkg::R_A;
                  d.dst_kind = cod_pkg::S_IMM16;
                end
                3'd6: begin
                  d.kind     = cod_pkg::K_LD;
                  d.sub      = cod_pkg::L_IO;
                  d.src_kind = cod_pkg::S_IND;
                  d.src_reg  = cod_pkg::R_C;
                  d.dst_kind = cod_pkg::S_REG;
                  d.dst_reg  = cod_pkg::R_A;
                end
                3'd7: begin
                  d.kind     = cod_pkg::K_LD;
                  d.sub      = cod_pkg::L_TYP;
                  d.src_kind = cod_pkg::S_IMM16;
                  d.dst_kind = cod_pkg::S_REG;
                  d.dst_reg  = cod_pkg::R_A;
                end
                default: begin
                  d.kind     = cod_pkg::K_JP;
                  d.src_kind = cod_pkg::S_IMM16;
                  d.cond     = cod_pkg::cond_of(y[1:0]);
                end
              endcase
            end
            3'd3: begin
              case (y)
                3'd0: begin
                  d.kind     = cod_pkg::K_JP;
                  d.src_kind = cod_pkg::S_IMM16;
                end
                3'd6:    d.kind = cod_pkg::K_DI;
                3'd7:    d.kind = cod_pkg::K_EI;
                default: bad = 1'b1;
              endcase
            end
            3'd4: begin
              if (!y[2]) begin
                d.kind     = cod_pkg::K_CALL;
                d.src_kind = cod_pkg::S_IMM16;
                d.cond     = cod_pkg::cond_of(y[1:0]);
              end else begin
                bad = 1'b1;
              end
            end
            3'd5: begin
              if (!q) begin
                d.kind     = cod_pkg::K_PUSH;
                d.src_kind = cod_pkg::S_PAIR;
                d.src_reg  = cod_pkg::r16af_reg(p);
              end else if (p == 2'd0) begin
                d.kind     = cod_pkg::K_CALL;
                d.src_kind = cod_pkg::S_IMM16;
              end else begin
                bad = 1'b1;
              end
            end
            3'd6: begin
              d.kind     = cod_pkg::alu_kind(y);
              d.src_kind = cod_pkg::S_IMM8;
              d.dst_kind = cod_pkg::S_REG;
              d.dst_reg  = cod_pkg::R_A;
            end
            default: begin
              d.kind = cod_pkg::K_RST;
              d.vec  = {y, 3'b000};
            end
          endcase
        end
      endcase
    end
    if (bad) begin
      d         = cod_pkg::DecZero;
      d.illegal = 1'b1;
    end
    dec_o = d;
  end

endmodule

>>> hdl/cpu_opcode_decoder.sv
`timescale 1ns / 1ps

// Channel   Dir  Contents
// s_axis    in   tdata[7:0] opcode_byte, tuser prefixed (after CB)
// m_axis    out  decoded word, fields listed at the port
//
// Two register stages: opcode register, decode logic, result register.
// Words pass the opcode register, then the result register; one per cycle
// sustained unless m_axis stalls, set by the single decode pass between them.
// Reset (rst_ni low, async) empties both stages; payload is not reset.
// A stall on m_axis fills the result register first, then the opcode
// register; s_axis_tready_o drops only when both are full.

`include "cpu_opcode_decoder_assert.svh"

module cpu_opcode_decoder (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [7:0]                     s_axis_tdata_i,  // [7:0] opcode_byte
  input  logic                           s_axis_tuser_i,  // [0] prefixed
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [0] illegal, [6:1] instr_kind, [9:7] load_subtype, [12:10] src_kind,
  // [16:13] src_reg, [19:17] dst_kind, [23:20] dst_reg, [26:24] cond_code,
  // [29:27] bit_index, [35:30] restart_vector, [39:36] zero
  output logic [cod_pkg::OutDataW-1:0]   m_axis_tdata_o
);

  // Opcode register
  logic          op_vld_q;
  logic          op_pfx_q;
  logic [7:0]    op_byte_q;

  // Result register
  logic          res_vld_q;
  cod_pkg::dec_t res_q;
  cod_pkg::dec_t res_d;

  logic res_free;
  logic op_free;
  logic in_acc;
  logic op_move;

  // Each stage takes a word when empty or when its word leaves this cycle.
  assign res_free = !res_vld_q || m_axis_tready_i;
  assign op_free  = !op_vld_q || res_free;
  assign in_acc   = s_axis_tvalid_i && op_free;
  assign op_move  = op_vld_q && res_free;

  assign s_axis_tready_o = op_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_vld_q <= 1'b0;
    end else if (op_free) begin
      op_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_pfx_q  <= s_axis_tuser_i;
      op_byte_q <= s_axis_tdata_i;
    end
  end

  cod_decode u_decode (
    .prefixed_i (op_pfx_q),
    .opcode_i   (op_byte_q),
    .dec_o      (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (res_free) begin
      res_vld_q <= op_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_move) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = res_vld_q;

  // Field order in the struct runs from illegal (MSB) to vec (LSB); the
  // bus wants illegal in bit 0, so lay the fields out one by one.
  assign m_axis_tdata_o = {
    {(cod_pkg::OutDataW - cod_pkg::DecW){1'b0}},
    res_q.vec,
    res_q.bit_idx,
    res_q.cond,
    res_q.dst_reg,
    res_q.dst_kind,
    res_q.src_reg,
    res_q.src_kind,
    res_q.sub,
    res_q.kind,
    res_q.illegal
  };

  // An illegal word carries nothing else.
  `COD_ASSERT_NOW(a_illegal_clean, m_axis_tvalid_o && m_axis_tdata_o[0],
                  m_axis_tdata_o[35:1] == 35'd0, "illegal result has nonzero fields")

  // Every CB-prefixed opcode is defined.
  `COD_ASSERT_NOW(a_cb_legal, op_vld_q && op_pfx_q, !res_d.illegal,
                  "prefixed opcode decoded as illegal")

  // An opcode that cannot advance stays in its register.
  `COD_ASSERT_NEXT(a_op_hold, op_vld_q && !res_free, op_vld_q && $stable(op_byte_q),
                   "stalled opcode lost or changed")

  // A decoded word moves into the result stage when that stage frees up.
  `COD_ASSERT_NEXT(a_res_fill, op_vld_q && res_free, res_vld_q,
                   "decoded word not captured")

endmodule
